/* design/rfc_pkg.sv */
// rfc_pkg: shared types, codes and constants of the rtp flow classifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rfc_pkg;

  localparam int CAND_ENTRIES_DEF = 64;
  localparam int RTP_ENTRIES_DEF  = 16;
  // index fields sized for the largest tables supported (1024 / 256 entries)
  localparam int CIDX_W = 10;
  localparam int RIDX_W = 8;
  localparam int CNT_W  = 3;
  localparam int TIME_W = 32;
  localparam int ID_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] PROMOTE_ABOVE = 3'd6;
  localparam logic [CNT_W-1:0] COUNT_FIRST   = 3'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAND_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTP_TIMEOUT  = 1'd1;

  typedef enum logic [1:0] {
    ST_RTP       = 2'd0,
    ST_NOT_RTP   = 2'd1,
    ST_CAND_FULL = 2'd2,
    ST_RTP_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AGE,
    S_SCAN,
    S_DECIDE
  } state_t;

  // search token handed from cell to cell along the candidate row
  typedef struct packed {
    logic              tok;
    logic              hit;
    logic [CIDX_W-1:0] hit_idx;
    logic [CNT_W-1:0]  hit_cnt;
    logic              free;
    logic [CIDX_W-1:0] free_idx;
  } cand_scan_t;

  // search token handed from cell to cell along the rtp row
  typedef struct packed {
    logic              tok;
    logic              hit;
    logic [RIDX_W-1:0] hit_idx;
    logic              free;
    logic [RIDX_W-1:0] free_idx;
  } rtp_scan_t;

  typedef struct packed {
    logic              we;
    logic [CIDX_W-1:0] idx;
    logic [CNT_W-1:0]  cnt;
  } cand_cmd_t;

  typedef struct packed {
    logic              we;
    logic [RIDX_W-1:0] idx;
  } rtp_cmd_t;

endpackage
`default_nettype wire

/* design/rtp_flow_classifier.sv */
// rtp_flow_classifier: top level, sequencer plus rows of candidate and rtp cells
// depends on rfc_pkg, rfc_cand_cell, rfc_rtp_cell
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_ssrc[31:0], in_now_seconds[31:0]
//  out     | output    | out_valid / out_ready | out_status[1:0], out_flow_index[3:0]
//  cfg     | input     | cfg_we (no wait)      | cfg_index[0], cfg_wdata[31:0]
//
// a word passes these steps in order: accept, ageing, the search token walking the
// longer row one cell per cycle, collection at the row end, leaving the scan step,
// and the decide/write step
// reset clears all valid bits and the sequencer and loads the timeouts (10 / 30) at once
// a result waits in the output register; the next word is taken meanwhile and
// holds in the decide step until the output register frees
`timescale 1ns / 1ps
`default_nettype none
module rtp_flow_classifier #(
  parameter int CAND_ENTRIES = rfc_pkg::CAND_ENTRIES_DEF,
  parameter int RTP_ENTRIES  = rfc_pkg::RTP_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [31:0]                  in_ssrc,
  input  wire logic [31:0]                  in_now_seconds,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [3:0]                        out_flow_index,
  input  wire logic                         cfg_we,
  input  wire logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                  cfg_wdata
);
  import rfc_pkg::*;

  // configuration
  logic [TIME_W-1:0] cand_timeout_r, rtp_timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_timeout_r <= TIME_W'(10);
      rtp_timeout_r  <= TIME_W'(30);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAND_TIMEOUT: cand_timeout_r <= cfg_wdata;
        CFG_RTP_TIMEOUT:  rtp_timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t state_r, state_nxt;
  logic [ID_W-1:0]   q_ssrc_r;
  logic [TIME_W-1:0] q_now_r;
  logic start_r;
  logic cand_done_r, rtp_done_r;
  cand_scan_t cand_res_r;
  rtp_scan_t  rtp_res_r;
  logic out_valid_r;
  status_t status_r;
  logic [RIDX_W-1:0] index_r;

  logic accept, fire;
  cand_cmd_t cand_cmd;
  rtp_cmd_t  rtp_cmd;
  status_t   status_nxt;
  logic [RIDX_W-1:0] index_nxt;
  logic [CNT_W-1:0]  new_cnt;

  // cell rows: token enters at cell 0, leaves after the last cell
  cand_scan_t cand_chain [CAND_ENTRIES+1];
  rtp_scan_t  rtp_chain  [RTP_ENTRIES+1];

  assign cand_chain[0] = '{tok: start_r, default: '0};
  assign rtp_chain[0]  = '{tok: start_r, default: '0};

  for (genvar i = 0; i < CAND_ENTRIES; i++) begin : g_cand
    rfc_cand_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .q_ssrc   (q_ssrc_r),
      .q_now    (q_now_r),
      .timeout  (cand_timeout_r),
      .age_en   (state_r == S_AGE),
      .cmd      (cand_cmd),
      .scan_in  (cand_chain[i]),
      .scan_out (cand_chain[i+1])
    );
  end

  for (genvar i = 0; i < RTP_ENTRIES; i++) begin : g_rtp
    rfc_rtp_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .q_ssrc   (q_ssrc_r),
      .q_now    (q_now_r),
      .timeout  (rtp_timeout_r),
      .age_en   (state_r == S_AGE),
      .cmd      (rtp_cmd),
      .scan_in  (rtp_chain[i]),
      .scan_out (rtp_chain[i+1])
    );
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // decide step may only commit when the output register can take the word
  assign fire     = (state_r == S_DECIDE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_AGE;
      S_AGE:    state_nxt = S_SCAN;
      S_SCAN:   if (cand_done_r && rtp_done_r) state_nxt = S_DECIDE;
      S_DECIDE: if (fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // query, token launch and collection at the row ends
  always_ff @(posedge clk) begin
    if (accept) begin
      q_ssrc_r <= in_ssrc;
      q_now_r  <= in_now_seconds;
    end
    if (cand_chain[CAND_ENTRIES].tok) cand_res_r <= cand_chain[CAND_ENTRIES];
    if (rtp_chain[RTP_ENTRIES].tok)   rtp_res_r  <= rtp_chain[RTP_ENTRIES];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b0;
      cand_done_r <= 1'b0;
      rtp_done_r  <= 1'b0;
    end else begin
      start_r <= (state_r == S_AGE);
      if (accept) begin
        cand_done_r <= 1'b0;
        rtp_done_r  <= 1'b0;
      end else begin
        if (cand_chain[CAND_ENTRIES].tok) cand_done_r <= 1'b1;
        if (rtp_chain[RTP_ENTRIES].tok)   rtp_done_r  <= 1'b1;
      end
    end
  end

  // decision and table writes
  assign new_cnt = (cand_res_r.hit_cnt <= PROMOTE_ABOVE) ?
                   cand_res_r.hit_cnt + CNT_W'(1) : cand_res_r.hit_cnt;

  always_comb begin
    cand_cmd   = '0;
    rtp_cmd    = '0;
    status_nxt = ST_NOT_RTP;
    index_nxt  = '0;
    priority if (rtp_res_r.hit) begin
      // known rtp flow: refresh its time
      rtp_cmd    = '{we: fire, idx: rtp_res_r.hit_idx};
      status_nxt = ST_RTP;
      index_nxt  = rtp_res_r.hit_idx;
    end else if (cand_res_r.hit) begin
      cand_cmd = '{we: fire, idx: cand_res_r.hit_idx, cnt: new_cnt};
      if (new_cnt > PROMOTE_ABOVE) begin
        // seventh packet: promote into lowest free rtp slot if any
        if (rtp_res_r.free) begin
          rtp_cmd    = '{we: fire, idx: rtp_res_r.free_idx};
          status_nxt = ST_RTP;
          index_nxt  = rtp_res_r.free_idx;
        end else begin
          status_nxt = ST_RTP_FULL;
        end
      end
    end else if (cand_res_r.free) begin
      // new flow opens a candidate entry
      cand_cmd = '{we: fire, idx: cand_res_r.free_idx, cnt: COUNT_FIRST};
    end else begin
      status_nxt = ST_CAND_FULL;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      status_r <= status_nxt;
      index_r  <= index_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_flow_index = 4'(index_r);

endmodule
`default_nettype wire

/* design/rfc_cand_cell.sv */
// rfc_cand_cell: one candidate table entry with ageing, compare and scan stage
// depends on rfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module rfc_cand_cell #(
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [rfc_pkg::ID_W-1:0]   q_ssrc,
  input  wire logic [rfc_pkg::TIME_W-1:0] q_now,
  input  wire logic [rfc_pkg::TIME_W-1:0] timeout,
  input  wire logic                      age_en,
  input  wire rfc_pkg::cand_cmd_t        cmd,
  input  wire rfc_pkg::cand_scan_t       scan_in,
  output rfc_pkg::cand_scan_t            scan_out
);
  import rfc_pkg::*;

  logic              valid_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] time_r;
  logic [CNT_W-1:0]  cnt_r;
  cand_scan_t        scan_r, scan_nxt;
  logic              sel, expired, mine;

  assign sel     = cmd.we && (cmd.idx == CIDX_W'(IDX));
  assign expired = (q_now - time_r) > timeout;
  assign mine    = valid_r && (id_r == q_ssrc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end else if (age_en && valid_r && expired) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      id_r   <= q_ssrc;
      time_r <= q_now;
      cnt_r  <= cmd.cnt;
    end
  end

  // lowest index wins: keep what an earlier cell found
  always_comb begin
    scan_nxt          = scan_in;
    scan_nxt.hit      = scan_in.hit || mine;
    scan_nxt.free     = scan_in.free || !valid_r;
    if (!scan_in.hit && mine) begin
      scan_nxt.hit_idx = CIDX_W'(IDX);
      scan_nxt.hit_cnt = cnt_r;
    end
    if (!scan_in.free && !valid_r) begin
      scan_nxt.free_idx = CIDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.tok <= 1'b0;
    end else begin
      scan_r.tok <= scan_in.tok;
    end
    if (scan_in.tok) begin
      scan_r.hit      <= scan_nxt.hit;
      scan_r.hit_idx  <= scan_nxt.hit_idx;
      scan_r.hit_cnt  <= scan_nxt.hit_cnt;
      scan_r.free     <= scan_nxt.free;
      scan_r.free_idx <= scan_nxt.free_idx;
    end
  end

  assign scan_out = scan_r;

endmodule
`default_nettype wire

/* design/rfc_rtp_cell.sv */
// rfc_rtp_cell: one rtp table entry with ageing, compare and scan stage
// depends on rfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module rfc_rtp_cell #(
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [rfc_pkg::ID_W-1:0]   q_ssrc,
  input  wire logic [rfc_pkg::TIME_W-1:0] q_now,
  input  wire logic [rfc_pkg::TIME_W-1:0] timeout,
  input  wire logic                      age_en,
  input  wire rfc_pkg::rtp_cmd_t         cmd,
  input  wire rfc_pkg::rtp_scan_t        scan_in,
  output rfc_pkg::rtp_scan_t             scan_out
);
  import rfc_pkg::*;

  logic              valid_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] time_r;
  rtp_scan_t         scan_r, scan_nxt;
  logic              sel, expired, mine;

  assign sel     = cmd.we && (cmd.idx == RIDX_W'(IDX));
  assign expired = (q_now - time_r) > timeout;
  assign mine    = valid_r && (id_r == q_ssrc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end else if (age_en && valid_r && expired) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      id_r   <= q_ssrc;
      time_r <= q_now;
    end
  end

  always_comb begin
    scan_nxt      = scan_in;
    scan_nxt.hit  = scan_in.hit || mine;
    scan_nxt.free = scan_in.free || !valid_r;
    if (!scan_in.hit && mine) begin
      scan_nxt.hit_idx = RIDX_W'(IDX);
    end
    if (!scan_in.free && !valid_r) begin
      scan_nxt.free_idx = RIDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.tok <= 1'b0;
    end else begin
      scan_r.tok <= scan_in.tok;
    end
    if (scan_in.tok) begin
      scan_r.hit      <= scan_nxt.hit;
      scan_r.hit_idx  <= scan_nxt.hit_idx;
      scan_r.free     <= scan_nxt.free;
      scan_r.free_idx <= scan_nxt.free_idx;
    end
  end

  assign scan_out = scan_r;

endmodule
`default_nettype wire

/* design/rfc_checker.sv */
// rfc_port_checks: port-level checks of the rtp flow classifier, bound to the top
// depends on rfc_pkg and rtp_flow_classifier
`timescale 1ns / 1ps
`default_nettype none
module rfc_port_checks (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [31:0] in_ssrc,
  input wire logic [31:0] in_now_seconds,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [3:0]  out_flow_index,
  input wire logic        cfg_we,
  input wire logic [0:0]  cfg_index,
  input wire logic [31:0] cfg_wdata
);
  import rfc_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_flow_index))
    else $error("result changed while stalled");

  // slot is reported only for rtp flows
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_RTP) |-> out_flow_index == 4'd0)
    else $error("flow index set on non-rtp status");

  // one word in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a result needs at least the ageing and scan cycles after its word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("result appeared too early");

endmodule

bind rtp_flow_classifier rfc_port_checks u_rfc_port_checks (.*);
`default_nettype wire
